/* sv/jri_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jri_pkg
// Shared constants, codes and controller/datapath link types for the
// journal record index.
// ----------------------------------------------------------------------------
package jri_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int SECTOR_BYTES  = 6144;
  localparam int MAX_PAYLOAD   = 6;
  localparam int HDR_BYTES     = 4;

  localparam int ACT_W = 2;
  localparam int ID_W  = 16;
  localparam int OFF_W = 13;
  localparam int LEN_W = 3;
  localparam int ST_W  = 3;
  localparam int SUM_W = OFF_W + 1;

  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RECORD = 2'd2;
  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd3;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
  localparam logic [ST_W-1:0] ST_NO_SPACE  = 3'd3;
  localparam logic [ST_W-1:0] ST_RESERVED  = 3'd4;
  localparam logic [ST_W-1:0] ST_BAD_LEN   = 3'd5;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

/* sv/jri_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jri_req_if
// Request channel: action and its operands.
// ----------------------------------------------------------------------------
interface jri_req_if;
  logic                        valid;
  logic                        ready;
  logic [jri_pkg::ACT_W-1:0]   action;
  logic [jri_pkg::ID_W-1:0]    record_id;
  logic [jri_pkg::OFF_W-1:0]   byte_offset;
  logic [jri_pkg::LEN_W-1:0]   payload_len;

  modport source (output valid, action, record_id, byte_offset, payload_len,
                  input ready);
  modport sink   (input valid, action, record_id, byte_offset, payload_len,
                  output ready);
endinterface

/* sv/jri_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jri_rsp_if
// Response channel: status, offset, overflow flag and journal end.
// ----------------------------------------------------------------------------
interface jri_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [jri_pkg::ST_W-1:0]    status;
  logic [jri_pkg::OFF_W-1:0]   result_offset;
  logic                        overflow_flag;
  logic [jri_pkg::OFF_W-1:0]   end_position;

  modport source (output valid, status, result_offset, overflow_flag, end_position,
                  input ready);
  modport sink   (input valid, status, result_offset, overflow_flag, end_position,
                  output ready);
endinterface

/* sv/jri_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jri_ctrl
// Sequencer: accept a request, walk the table, then execute once the
// response register is free.
// ----------------------------------------------------------------------------
module jri_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  jri_pkg::sts_t sts,
  output jri_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.exec      = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* sv/jri_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jri_dpath
// Request latch, id/offset tables, scan pipeline, action decode,
// journal state and response register.
// ----------------------------------------------------------------------------
module jri_dpath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [jri_pkg::ID_W-1:0]   cfg_wr_data,
  input  logic [jri_pkg::ACT_W-1:0]  in_action,
  input  logic [jri_pkg::ID_W-1:0]   in_record_id,
  input  logic [jri_pkg::OFF_W-1:0]  in_byte_offset,
  input  logic [jri_pkg::LEN_W-1:0]  in_payload_len,
  input  jri_pkg::cmd_t              cmd,
  output jri_pkg::sts_t              sts,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [jri_pkg::ST_W-1:0]   out_status,
  output logic [jri_pkg::OFF_W-1:0]  out_result_offset,
  output logic                       out_overflow_flag,
  output logic [jri_pkg::OFF_W-1:0]  out_end_position
);

  logic [jri_pkg::ID_W-1:0]  id_mem  [jri_pkg::TABLE_ENTRIES];
  logic [jri_pkg::OFF_W-1:0] off_mem [jri_pkg::TABLE_ENTRIES];

  logic [jri_pkg::ID_W-1:0]  reserved_id;
  logic [jri_pkg::ACT_W-1:0] act_q;
  logic [jri_pkg::ID_W-1:0]  id_q;
  logic [jri_pkg::OFF_W-1:0] off_q;
  logic [jri_pkg::LEN_W-1:0] len_q;

  logic [jri_pkg::CNT_W-1:0] entry_count;
  logic                      overflow_seen;
  logic [jri_pkg::OFF_W-1:0] journal_end;

  logic [jri_pkg::CNT_W-1:0] scan_idx;
  logic                      rd_pend;
  logic [jri_pkg::IDX_W-1:0] rd_slot;
  logic [jri_pkg::ID_W-1:0]  rd_id;
  logic [jri_pkg::OFF_W-1:0] rd_off;
  logic                      hit;
  logic [jri_pkg::IDX_W-1:0] hit_slot;
  logic [jri_pkg::OFF_W-1:0] hit_off;

  logic scan_done;
  logic rd_match;
  logic rd_en;

  logic [jri_pkg::ST_W-1:0]  st_c;
  logic [jri_pkg::OFF_W-1:0] res_c;
  logic [jri_pkg::CNT_W-1:0] count_next;
  logic                      overflow_next;
  logic [jri_pkg::OFF_W-1:0] end_next;
  logic                      id_we;
  logic                      off_we;
  logic [jri_pkg::IDX_W-1:0] wr_slot;
  logic [jri_pkg::OFF_W-1:0] wr_off;

  logic                      len_ok;
  logic                      is_reserved;
  logic                      table_full;
  logic [3:0]                padded;
  logic [4:0]                ent_bytes;
  logic [jri_pkg::SUM_W-1:0] total_rec;
  logic [jri_pkg::SUM_W-1:0] total_app;
  logic [jri_pkg::OFF_W-1:0] clear_end;

  // scan: one read issued per cycle, compared against the request id in the next cycle
  assign scan_done = hit || (!rd_pend && (scan_idx >= entry_count));
  assign rd_match  = rd_pend && (rd_id == id_q);
  assign rd_en     = cmd.scan_step && !scan_done && !rd_match && (scan_idx < entry_count);

  assign sts.scan_done = scan_done;
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_id <= '0;
    end else if (cfg_wr_en) begin
      reserved_id <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q <= in_action;
      id_q  <= in_record_id;
      off_q <= in_byte_offset;
      len_q <= in_payload_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_id   <= id_mem[scan_idx[jri_pkg::IDX_W-1:0]];
      rd_off  <= off_mem[scan_idx[jri_pkg::IDX_W-1:0]];
      rd_slot <= scan_idx[jri_pkg::IDX_W-1:0];
    end
    if (rd_match && cmd.scan_step) begin
      hit_slot <= rd_slot;
      hit_off  <= rd_off;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      rd_pend  <= 1'b0;
      hit      <= 1'b0;
    end else if (cmd.load) begin
      scan_idx <= '0;
      rd_pend  <= 1'b0;
      hit      <= 1'b0;
    end else if (cmd.scan_step && !scan_done) begin
      if (rd_match) begin
        hit <= 1'b1;
      end
      rd_pend <= rd_en;
      if (rd_en) begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
  end

  // action decode
  assign len_ok      = (len_q != '0) && (len_q <= jri_pkg::LEN_W'(jri_pkg::MAX_PAYLOAD));
  assign is_reserved = (id_q == reserved_id);
  assign table_full  = (entry_count >= jri_pkg::CNT_W'(jri_pkg::TABLE_ENTRIES));
  assign padded      = ({1'b0, len_q} + 4'd1) & 4'b1110;
  assign ent_bytes   = 5'(jri_pkg::HDR_BYTES) + {1'b0, padded};
  assign total_rec   = {1'b0, off_q} + jri_pkg::SUM_W'(ent_bytes);
  assign total_app   = {1'b0, journal_end} + jri_pkg::SUM_W'(ent_bytes);
  assign clear_end   = (off_q > jri_pkg::OFF_W'(jri_pkg::SECTOR_BYTES)) ?
                       jri_pkg::OFF_W'(jri_pkg::SECTOR_BYTES) : off_q;

  always_comb begin
    st_c          = jri_pkg::ST_OK;
    res_c         = '0;
    count_next    = entry_count;
    overflow_next = overflow_seen;
    end_next      = journal_end;
    id_we         = 1'b0;
    off_we        = 1'b0;
    wr_slot       = entry_count[jri_pkg::IDX_W-1:0];
    wr_off        = off_q;
    unique case (act_q)
      jri_pkg::ACT_CLEAR: begin
        count_next    = '0;
        overflow_next = 1'b0;
        end_next      = clear_end;
      end
      jri_pkg::ACT_LOOKUP: begin
        if (!is_reserved && hit) begin
          res_c = hit_off;
        end else begin
          st_c = jri_pkg::ST_NOT_FOUND;
        end
      end
      jri_pkg::ACT_RECORD: begin
        priority if (!len_ok) begin
          st_c = jri_pkg::ST_BAD_LEN;
        end else if (total_rec > jri_pkg::SUM_W'(jri_pkg::SECTOR_BYTES)) begin
          st_c = jri_pkg::ST_NO_SPACE;
        end else if (is_reserved) begin
          end_next = total_rec[jri_pkg::OFF_W-1:0];
        end else if (hit) begin
          off_we   = 1'b1;
          wr_slot  = hit_slot;
          end_next = total_rec[jri_pkg::OFF_W-1:0];
        end else if (table_full) begin
          overflow_next = 1'b1;
          st_c          = jri_pkg::ST_FULL;
        end else begin
          id_we      = 1'b1;
          off_we     = 1'b1;
          count_next = entry_count + 1'b1;
          end_next   = total_rec[jri_pkg::OFF_W-1:0];
        end
      end
      jri_pkg::ACT_APPEND: begin
        priority if (is_reserved) begin
          st_c = jri_pkg::ST_RESERVED;
        end else if (!len_ok) begin
          st_c = jri_pkg::ST_BAD_LEN;
        end else if (!hit && table_full) begin
          st_c = jri_pkg::ST_FULL;
        end else if (total_app > jri_pkg::SUM_W'(jri_pkg::SECTOR_BYTES)) begin
          st_c = jri_pkg::ST_NO_SPACE;
        end else begin
          res_c    = journal_end;
          wr_off   = journal_end;
          off_we   = 1'b1;
          end_next = total_app[jri_pkg::OFF_W-1:0];
          if (hit) begin
            wr_slot = hit_slot;
          end else begin
            id_we      = 1'b1;
            count_next = entry_count + 1'b1;
          end
        end
      end
      default: begin
        st_c = jri_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && id_we) begin
      id_mem[wr_slot] <= id_q;
    end
    if (cmd.exec && off_we) begin
      off_mem[wr_slot] <= wr_off;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count   <= '0;
      overflow_seen <= 1'b0;
      journal_end   <= '0;
    end else if (cmd.exec) begin
      entry_count   <= count_next;
      overflow_seen <= overflow_next;
      journal_end   <= end_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status        <= st_c;
      out_result_offset <= res_c;
      out_overflow_flag <= overflow_next;
      out_end_position  <= end_next;
    end
  end

endmodule

/* sv/journal_record_index_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// journal_record_index_unit
// Record index for an append-only flash journal sector.
// ----------------------------------------------------------------------------
// Usage:
//   req  : valid/ready request channel carrying action, record_id,
//          byte_offset and payload_len. One request is taken when idle.
//   rsp  : valid/ready response channel, one response per request, held
//          in an output register until taken.
//   cfg  : cfg_wr_en/cfg_wr_data write reserved_id; write only while idle.
// Timing: every request walks the filled part of the table until an id
//   matches, one entry per cycle through the registered table read port,
//   then executes once the response register is free. The next request
//   is taken only after the previous one has executed.
// Stall: while rsp is not taken, the next request is still accepted and
//   walked; it waits to execute until the response register frees up.
// Reset: entry count, overflow flag, journal end and reserved_id clear to
//   zero; table contents are not cleared and only filled entries are read.
// ----------------------------------------------------------------------------
module journal_record_index_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [jri_pkg::ID_W-1:0]  cfg_wr_data,
  jri_req_if.sink                   req,
  jri_rsp_if.source                 rsp
);

  jri_pkg::cmd_t cmd;
  jri_pkg::sts_t sts;
  logic          in_ready;

  assign req.ready = in_ready;

  jri_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  jri_dpath u_dpath (
    .clk               (clk),
    .rst               (rst),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_action         (req.action),
    .in_record_id      (req.record_id),
    .in_byte_offset    (req.byte_offset),
    .in_payload_len    (req.payload_len),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (rsp.valid),
    .out_ready         (rsp.ready),
    .out_status        (rsp.status),
    .out_result_offset (rsp.result_offset),
    .out_overflow_flag (rsp.overflow_flag),
    .out_end_position  (rsp.end_position)
  );

endmodule
